@@ sv/jdg_pkg.sv @@
// constants, widths and shared types of the julian date to gregorian converter
// depends on nothing; every other file refers to it by scoped names
package jdg_pkg;

  // input format
  localparam int DAY_BITS      = 23;
  localparam int FRACTION_BITS = 32;
  localparam int IN_W          = 55;

  // output field widths
  localparam int YEAR_W   = 15;
  localparam int MONTH_W  = 4;
  localparam int DOM_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int MILLIS_W = 16;
  localparam int DOW_W    = 3;

  // pipeline depth, input beat to output beat
  localparam int NUM_STAGES = 8;

  // calendar epoch of the algorithm
  localparam int EPOCH_DAY = 1721119;
  localparam int T_OFS     = 4 * EPOCH_DAY + 1;

  // shifted day number, its scaled form and the day-of-week operand
  localparam int DAYP_W = DAY_BITS + 1;
  localparam int TX_W   = DAYP_W + 2;
  localparam int T_W    = DAY_BITS + 2;
  localparam int W_W    = DAY_BITS + 1;

  // quotient by the days of four centuries
  localparam int DIV_YR = 146097;
  localparam int S1     = T_W + 18;
  localparam int M1_W   = S1 - 17;
  localparam int P1_W   = T_W + M1_W;
  localparam int Y_W    = T_W - 17;
  localparam logic [M1_W-1:0] M1 =
    M1_W'(((64'd1 << S1) + 64'd146096) / 64'd146097);

  // remainder within four centuries and the scaled day
  localparam int R_W = 18;
  localparam int U_W = 18;

  // quotient by the days of four years
  localparam int DIV_QY = 1461;
  localparam int S2     = U_W + 11;
  localparam int M2_W   = S2 - 10;
  localparam int P2_W   = U_W + M2_W;
  localparam int Q_W    = 7;
  localparam logic [M2_W-1:0] M2 =
    M2_W'(((64'd1 << S2) + 64'd1460) / 64'd1461);
  localparam int YY_W   = Y_W + 7;

  // day of year and month quotient by 153
  localparam int D2_W   = 11;
  localparam int D3_W   = 9;
  localparam int V_W    = 11;
  localparam int DIV_MO = 153;
  localparam int S3     = V_W + 8;
  localparam int M3_W   = S3 - 7;
  localparam int P3_W   = V_W + M3_W;
  localparam int MQ_W   = 4;
  localparam logic [M3_W-1:0] M3 =
    M3_W'(((64'd1 << S3) + 64'd152) / 64'd153);
  localparam int D4_W   = 8;

  // day of month by reciprocal of five
  localparam int S4   = 10;
  localparam int M4_W = 8;
  localparam int P4_W = D4_W + M4_W;
  localparam logic [M4_W-1:0] M4 = M4_W'(((64'd1 << S4) + 64'd4) / 64'd5);

  // day of week by reciprocal of seven
  localparam int S7   = W_W + 3;
  localparam int M7_W = S7 - 2;
  localparam int P7_W = W_W + M7_W;
  localparam int Q7_W = W_W - 2;
  localparam logic [M7_W-1:0] M7 =
    M7_W'(((64'd1 << S7) + 64'd6) / 64'd7);

  // month threshold where the year rolls over
  localparam int MONTH_WRAP = 10;

  // time-of-day products
  localparam int HR_MUL   = 24;
  localparam int MIN_MUL  = 1440;
  localparam int MS_MUL   = 86400000;
  localparam int PH_W     = FRACTION_BITS + 5;
  localparam int PM_W     = FRACTION_BITS + 11;
  localparam int PT_W     = FRACTION_BITS + 27;
  localparam int MINS_W   = 11;
  localparam int MST_W    = 27;
  localparam int MS_PER_MIN = 60000;
  localparam int MIN_PER_HR = 60;

  // stage load enables, one per register stage
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } pipe_ctl_t;

  // time of day fields
  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [MILLIS_W-1:0] millis;
  } tod_t;

endpackage

@@ sv/jdg_in_if.sv @@
// input channel: one julian date per beat
// depends on jdg_pkg for the field width
interface jdg_in_if;
  logic                       valid;
  logic                       ready;
  logic [jdg_pkg::IN_W-1:0]   julian_date_fixed;

  modport source (output valid, output julian_date_fixed, input ready);
  modport sink (input valid, input julian_date_fixed, output ready);
endinterface

@@ sv/jdg_out_if.sv @@
// output channel: calendar date, time of day and day of week per beat
// depends on jdg_pkg for the field widths
interface jdg_out_if;
  logic                           valid;
  logic                           ready;
  logic [jdg_pkg::YEAR_W-1:0]     year;
  logic [jdg_pkg::MONTH_W-1:0]    month;
  logic [jdg_pkg::DOM_W-1:0]      day_of_month;
  logic [jdg_pkg::HOUR_W-1:0]     hour;
  logic [jdg_pkg::MINUTE_W-1:0]   minute;
  logic [jdg_pkg::MILLIS_W-1:0]   millis_of_minute;
  logic [jdg_pkg::DOW_W-1:0]      day_of_week;
  logic                           out_of_range;

  modport source (
    output valid, output year, output month, output day_of_month, output hour,
    output minute, output millis_of_minute, output day_of_week,
    output out_of_range, input ready
  );
  modport sink (
    input valid, input year, input month, input day_of_month, input hour,
    input minute, input millis_of_minute, input day_of_week,
    input out_of_range, output ready
  );
endinterface

@@ sv/jdg_pipe_ctl.sv @@
// valid bits and per-stage load enables of the conversion pipeline
// depends on jdg_pkg; empty stages absorb bubbles while the output stalls
module jdg_pipe_ctl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_ready_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output jdg_pkg::pipe_ctl_t ctl_o
);

  logic [jdg_pkg::NUM_STAGES-1:0] valid_q, valid_d, en;

  // a stage may load when it is empty or its beat moves on
  always_comb begin
    en[jdg_pkg::NUM_STAGES-1] = !valid_q[jdg_pkg::NUM_STAGES-1] || out_ready_i;
    for (int k = jdg_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  // valid bits follow the data
  always_comb begin
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < jdg_pkg::NUM_STAGES; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctl_o.en    = en;
  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[jdg_pkg::NUM_STAGES-1];

endmodule

@@ sv/jdg_time.sv @@
// time of day: hour, minute and milliseconds from the shifted day fraction
// depends on jdg_pkg; aligned to the calendar pipeline by a delay line
module jdg_time (
  input  logic                              clk_i,
  input  jdg_pkg::pipe_ctl_t                ctl_i,
  input  logic [jdg_pkg::FRACTION_BITS-1:0] frac_i,
  output jdg_pkg::tod_t                     tod_o
);

  logic [jdg_pkg::FRACTION_BITS-1:0] frac_q, frac_sh;
  logic [jdg_pkg::PH_W-1:0]          ph;
  logic [jdg_pkg::PM_W-1:0]          pm;
  logic [jdg_pkg::PT_W-1:0]          pt;
  logic [jdg_pkg::HOUR_W-1:0]        hr_q;
  logic [jdg_pkg::MINS_W-1:0]        mins_q, min_sub, min_diff;
  logic [jdg_pkg::MST_W-1:0]         mst_q, ms_sub, ms_diff;
  jdg_pkg::tod_t                     tod_d;
  jdg_pkg::tod_t                     tod_q [2:jdg_pkg::NUM_STAGES-1];

  // noon to midnight: the top fraction bit flips
  assign frac_sh = {~frac_i[jdg_pkg::FRACTION_BITS-1], frac_i[jdg_pkg::FRACTION_BITS-2:0]};

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      frac_q <= frac_sh;
    end
  end

  // fraction times hours, minutes and milliseconds per day
  assign ph = jdg_pkg::PH_W'(frac_q) * jdg_pkg::PH_W'(jdg_pkg::HR_MUL);
  assign pm = jdg_pkg::PM_W'(frac_q) * jdg_pkg::PM_W'(jdg_pkg::MIN_MUL);
  assign pt = jdg_pkg::PT_W'(frac_q) * jdg_pkg::PT_W'(jdg_pkg::MS_MUL);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1]) begin
      hr_q   <= ph[jdg_pkg::FRACTION_BITS +: jdg_pkg::HOUR_W];
      mins_q <= pm[jdg_pkg::FRACTION_BITS +: jdg_pkg::MINS_W];
      mst_q  <= pt[jdg_pkg::FRACTION_BITS +: jdg_pkg::MST_W];
    end
  end

  // remove whole hours and whole minutes
  assign min_sub  = jdg_pkg::MINS_W'(hr_q) * jdg_pkg::MINS_W'(jdg_pkg::MIN_PER_HR);
  assign min_diff = mins_q - min_sub;
  assign ms_sub   = jdg_pkg::MST_W'(mins_q) * jdg_pkg::MST_W'(jdg_pkg::MS_PER_MIN);
  assign ms_diff  = mst_q - ms_sub;

  always_comb begin
    tod_d.hour   = hr_q;
    tod_d.minute = min_diff[jdg_pkg::MINUTE_W-1:0];
    tod_d.millis = ms_diff[jdg_pkg::MILLIS_W-1:0];
  end

  // delay line to the output stage
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[2]) begin
      tod_q[2] <= tod_d;
    end
    for (int k = 3; k < jdg_pkg::NUM_STAGES; k++) begin
      if (ctl_i.en[k]) begin
        tod_q[k] <= tod_q[k-1];
      end
    end
  end

  assign tod_o = tod_q[jdg_pkg::NUM_STAGES-1];

endmodule

@@ sv/jdg_calendar.sv @@
// gregorian year, month, day and day of week from the julian day number
// depends on jdg_pkg; constant divisions by reciprocal multiply across the stages
module jdg_calendar (
  input  logic                          clk_i,
  input  jdg_pkg::pipe_ctl_t            ctl_i,
  input  logic [jdg_pkg::DAY_BITS-1:0]  day_i,
  input  logic                          frac_msb_i,
  output logic [jdg_pkg::YEAR_W-1:0]    year_o,
  output logic [jdg_pkg::MONTH_W-1:0]   month_o,
  output logic [jdg_pkg::DOM_W-1:0]     dom_o,
  output logic [jdg_pkg::DOW_W-1:0]     dow_o,
  output logic                          oor_o
);

  // stage 1 signals
  logic [jdg_pkg::DAYP_W-1:0] day_p;
  logic [jdg_pkg::TX_W-1:0]   tx;
  logic [jdg_pkg::T_W-1:0]    s1_t_q;
  logic                       s1_jz_q;
  logic [jdg_pkg::W_W-1:0]    s1_w_q;
  logic                       oor_q [0:jdg_pkg::NUM_STAGES-1];

  // stage 2 signals
  logic [jdg_pkg::P1_W-1:0]   p1;
  logic [jdg_pkg::P7_W-1:0]   p7;
  logic [jdg_pkg::T_W-1:0]    s2_t_q;
  logic                       s2_jz_q;
  logic [jdg_pkg::Y_W-1:0]    s2_y_q;
  logic [jdg_pkg::W_W-1:0]    s2_w_q;
  logic [jdg_pkg::Q7_W-1:0]   s2_q7_q;

  // stage 3 signals
  logic [jdg_pkg::T_W-1:0]    yr_mul, r_full;
  logic [jdg_pkg::W_W-1:0]    dw_mul, dw_full;
  logic [jdg_pkg::U_W-1:0]    s3_u_q;
  logic [jdg_pkg::Y_W-1:0]    s3_y_q;
  logic [jdg_pkg::DOW_W-1:0]  dow_q [2:jdg_pkg::NUM_STAGES-1];

  // stage 4 signals
  logic [jdg_pkg::P2_W-1:0]   p2;
  logic [jdg_pkg::U_W-1:0]    s4_u_q;
  logic [jdg_pkg::Y_W-1:0]    s4_y_q;
  logic [jdg_pkg::Q_W-1:0]    s4_q_q;

  // stage 5 signals
  logic [jdg_pkg::U_W-1:0]    qy_mul, d2_full;
  logic [jdg_pkg::D3_W-1:0]   s5_d3_q;
  logic [jdg_pkg::YY_W-1:0]   s5_yy_q;

  // stage 6 signals
  logic [jdg_pkg::V_W-1:0]    v;
  logic [jdg_pkg::P3_W-1:0]   p3;
  logic [jdg_pkg::V_W-1:0]    s6_v_q;
  logic [jdg_pkg::MQ_W-1:0]   s6_mq_q;
  logic [jdg_pkg::YY_W-1:0]   s6_yy_q;

  // stage 7 signals
  logic [jdg_pkg::V_W-1:0]    mo_mul, d4_full;
  logic [jdg_pkg::D4_W-1:0]   s7_d4_q;
  logic [jdg_pkg::MQ_W-1:0]   s7_mq_q;
  logic [jdg_pkg::YY_W-1:0]   s7_yy_q;

  // stage 8 signals
  logic [jdg_pkg::D4_W-1:0]   d5;
  logic [jdg_pkg::P4_W-1:0]   p4;
  logic                       wrap;
  logic [jdg_pkg::YY_W-1:0]   yy_adj;
  logic [jdg_pkg::YEAR_W-1:0]  year_q;
  logic [jdg_pkg::MONTH_W-1:0] month_q;
  logic [jdg_pkg::DOM_W-1:0]   dom_q;

  // stage 1: midnight shift, epoch compare, 4j-1
  assign day_p = jdg_pkg::DAYP_W'(day_i) + jdg_pkg::DAYP_W'(frac_msb_i);
  assign tx    = {day_p, 2'b00} - jdg_pkg::TX_W'(jdg_pkg::T_OFS);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      s1_jz_q  <= day_p == jdg_pkg::DAYP_W'(jdg_pkg::EPOCH_DAY);
      s1_t_q   <= tx[jdg_pkg::T_W-1:0];
      s1_w_q   <= day_p + jdg_pkg::W_W'(1);
    end
  end

  // stage 2: century quotient and week quotient
  assign p1 = jdg_pkg::P1_W'(s1_t_q) * jdg_pkg::P1_W'(jdg_pkg::M1);
  assign p7 = jdg_pkg::P7_W'(s1_w_q) * jdg_pkg::P7_W'(jdg_pkg::M7);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1]) begin
      s2_t_q  <= s1_t_q;
      s2_jz_q <= s1_jz_q;
      s2_y_q  <= p1[jdg_pkg::S1 +: jdg_pkg::Y_W];
      s2_w_q  <= s1_w_q;
      s2_q7_q <= p7[jdg_pkg::S7 +: jdg_pkg::Q7_W];
    end
  end

  // stage 3: remainder in the cycle, day of week; the epoch day itself is year 0 day 0
  assign yr_mul  = jdg_pkg::T_W'(s2_y_q) * jdg_pkg::T_W'(jdg_pkg::DIV_YR);
  assign r_full  = s2_t_q - yr_mul;
  assign dw_mul  = jdg_pkg::W_W'(s2_q7_q) * jdg_pkg::W_W'(7);
  assign dw_full = s2_w_q - dw_mul;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[2]) begin
      if (s2_jz_q) begin
        s3_u_q <= jdg_pkg::U_W'(3);
        s3_y_q <= '0;
      end else begin
        s3_u_q <= {r_full[jdg_pkg::R_W-1:2], 2'b11};
        s3_y_q <= s2_y_q;
      end
    end
  end

  // stage 4: quotient by four years
  assign p2 = jdg_pkg::P2_W'(s3_u_q) * jdg_pkg::P2_W'(jdg_pkg::M2);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[3]) begin
      s4_u_q <= s3_u_q;
      s4_y_q <= s3_y_q;
      s4_q_q <= p2[jdg_pkg::S2 +: jdg_pkg::Q_W];
    end
  end

  // stage 5: day of year and raw year
  assign qy_mul  = jdg_pkg::U_W'(s4_q_q) * jdg_pkg::U_W'(jdg_pkg::DIV_QY);
  assign d2_full = s4_u_q - qy_mul;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[4]) begin
      s5_d3_q <= d2_full[jdg_pkg::D2_W-1:2] + jdg_pkg::D3_W'(1);
      s5_yy_q <= jdg_pkg::YY_W'(s4_y_q) * jdg_pkg::YY_W'(100) + jdg_pkg::YY_W'(s4_q_q);
    end
  end

  // stage 6: 5d-3 by shift and add, month quotient
  assign v  = {s5_d3_q, 2'b00} + jdg_pkg::V_W'(s5_d3_q) - jdg_pkg::V_W'(3);
  assign p3 = jdg_pkg::P3_W'(v) * jdg_pkg::P3_W'(jdg_pkg::M3);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[5]) begin
      s6_v_q  <= v;
      s6_mq_q <= p3[jdg_pkg::S3 +: jdg_pkg::MQ_W];
      s6_yy_q <= s5_yy_q;
    end
  end

  // stage 7: remainder within the month
  assign mo_mul  = jdg_pkg::V_W'(s6_mq_q) * jdg_pkg::V_W'(jdg_pkg::DIV_MO);
  assign d4_full = s6_v_q - mo_mul;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[6]) begin
      s7_d4_q <= d4_full[jdg_pkg::D4_W-1:0];
      s7_mq_q <= s6_mq_q;
      s7_yy_q <= s6_yy_q;
    end
  end

  // stage 8: day of month, month and year rollover
  assign d5     = s7_d4_q + jdg_pkg::D4_W'(5);
  assign p4     = jdg_pkg::P4_W'(d5) * jdg_pkg::P4_W'(jdg_pkg::M4);
  assign wrap   = s7_mq_q >= jdg_pkg::MQ_W'(jdg_pkg::MONTH_WRAP);
  assign yy_adj = s7_yy_q + jdg_pkg::YY_W'(wrap);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[7]) begin
      dom_q  <= p4[jdg_pkg::S4 +: jdg_pkg::DOM_W];
      year_q <= yy_adj[jdg_pkg::YEAR_W-1:0];
      if (wrap) begin
        month_q <= s7_mq_q - jdg_pkg::MONTH_W'(9);
      end else begin
        month_q <= s7_mq_q + jdg_pkg::MONTH_W'(3);
      end
    end
  end

  // range flag from stage 1 and day of week from stage 3 ride along
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      oor_q[0] <= day_p < jdg_pkg::DAYP_W'(jdg_pkg::EPOCH_DAY);
    end
    for (int k = 1; k < jdg_pkg::NUM_STAGES; k++) begin
      if (ctl_i.en[k]) begin
        oor_q[k] <= oor_q[k-1];
      end
    end
    if (ctl_i.en[2]) begin
      dow_q[2] <= dw_full[jdg_pkg::DOW_W-1:0];
    end
    for (int k = 3; k < jdg_pkg::NUM_STAGES; k++) begin
      if (ctl_i.en[k]) begin
        dow_q[k] <= dow_q[k-1];
      end
    end
  end

  assign year_o  = year_q;
  assign month_o = month_q;
  assign dom_o   = dom_q;
  assign dow_o   = dow_q[jdg_pkg::NUM_STAGES-1];
  assign oor_o   = oor_q[jdg_pkg::NUM_STAGES-1];

endmodule

@@ sv/julian_date_to_gregorian.sv @@
// top level: julian date in fixed point to gregorian date and time of day
// depends on jdg_pkg, jdg_in_if, jdg_out_if, jdg_pipe_ctl, jdg_calendar, jdg_time
//
//   channel  dir  beat carries
//   in_i     in   julian_date_fixed (23 day bits, 32 fraction bits)
//   out_o    out  year, month, day_of_month, hour, minute, millis_of_minute,
//                 day_of_week, out_of_range
//
// one beat per cycle sustained while out_o.ready stays high; the depth is set
// by the chain of constant-divisor steps, each one reciprocal multiply or
// multiply-subtract per stage.
// reset clears only the stage valid bits; the pipeline is empty after reset.
// an output stall holds the last stage; earlier empty stages keep loading,
// so in_i.ready stays high until every stage holds a beat.
module julian_date_to_gregorian (
  input  logic       clk_i,
  input  logic       rst_ni,
  jdg_in_if.sink     in_i,
  jdg_out_if.source  out_o
);

  jdg_pkg::pipe_ctl_t               ctl;
  logic [jdg_pkg::YEAR_W-1:0]       cal_year;
  logic [jdg_pkg::MONTH_W-1:0]      cal_month;
  logic [jdg_pkg::DOM_W-1:0]        cal_dom;
  logic [jdg_pkg::DOW_W-1:0]        cal_dow;
  logic                             cal_oor;
  jdg_pkg::tod_t                    tod;

  // handshake and stage enables
  jdg_pipe_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .ctl_o       (ctl)
  );

  // date path
  jdg_calendar u_calendar (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .day_i      (in_i.julian_date_fixed[jdg_pkg::FRACTION_BITS +: jdg_pkg::DAY_BITS]),
    .frac_msb_i (in_i.julian_date_fixed[jdg_pkg::FRACTION_BITS-1]),
    .year_o     (cal_year),
    .month_o    (cal_month),
    .dom_o      (cal_dom),
    .dow_o      (cal_dow),
    .oor_o      (cal_oor)
  );

  // time path
  jdg_time u_time (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .frac_i (in_i.julian_date_fixed[jdg_pkg::FRACTION_BITS-1:0]),
    .tod_o  (tod)
  );

  // days before the epoch report only the flag
  assign out_o.year             = cal_oor ? '0 : cal_year;
  assign out_o.month            = cal_oor ? '0 : cal_month;
  assign out_o.day_of_month     = cal_oor ? '0 : cal_dom;
  assign out_o.hour             = cal_oor ? '0 : tod.hour;
  assign out_o.minute           = cal_oor ? '0 : tod.minute;
  assign out_o.millis_of_minute = cal_oor ? '0 : tod.millis;
  assign out_o.day_of_week      = cal_oor ? '0 : cal_dow;
  assign out_o.out_of_range     = cal_oor;

endmodule
